[hdl/fla_pkg.sv]
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the lease-based fifo lock arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package fla_pkg;

   // widths fixed by the request and result fields
   localparam int NW = 4;
   localparam int LEASE_W = 20;
   localparam int CMD_W = 2;
   localparam int OUTCOME_W = 3;
   localparam int COUNT_OUT_W = 5;
   localparam int NODE_LIMIT = 1 << NW;
   localparam logic [LEASE_W-1:0] LEASE_RESET = LEASE_W'(1000);

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   // result outcome codes
   localparam logic [OUTCOME_W-1:0] OC_GRANTED   = 3'd0;
   localparam logic [OUTCOME_W-1:0] OC_QUEUED    = 3'd1;
   localparam logic [OUTCOME_W-1:0] OC_ALREADY   = 3'd2;
   localparam logic [OUTCOME_W-1:0] OC_RELEASED  = 3'd3;
   localparam logic [OUTCOME_W-1:0] OC_WITHDRAWN = 3'd4;
   localparam logic [OUTCOME_W-1:0] OC_IGNORED   = 3'd5;
   localparam logic [OUTCOME_W-1:0] OC_EXPIRED   = 3'd6;
   localparam logic [OUTCOME_W-1:0] OC_TICK      = 3'd7;

   // access to the link memories, from the control core
   typedef struct packed {
      logic          rd_en;
      logic [NW-1:0] rd_next_addr;
      logic [NW-1:0] rd_prev_addr;
      logic          wr_next_en;
      logic [NW-1:0] wr_next_addr;
      logic [NW-1:0] wr_next_data;
      logic          wr_prev_en;
      logic [NW-1:0] wr_prev_addr;
      logic [NW-1:0] wr_prev_data;
   } mem_req_type;

   // registered read data of the link memories
   typedef struct packed {
      logic [NW-1:0] next_node;
      logic [NW-1:0] prev_node;
   } mem_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } fsm_state_type;

endpackage

`default_nettype wire

[hdl/fla_link_mem.sv]
// ----------------------------------------------------------------------------
// fla_link_mem
// Next and previous link memories of the wait queue, one entry per node,
// each with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_link_mem #(
   parameter int DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire fla_pkg::mem_req_type mem_req,
   output      fla_pkg::mem_rsp_type mem_rsp
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [AW-1:0] next_mem [DEPTH];
   logic [AW-1:0] prev_mem [DEPTH];
   logic [AW-1:0] rd_next_ff;
   logic [AW-1:0] rd_prev_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_next_en) begin
         next_mem[mem_req.wr_next_addr[AW-1:0]] <= mem_req.wr_next_data[AW-1:0];
      end
      if (mem_req.rd_en) begin
         rd_next_ff <= next_mem[mem_req.rd_next_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_prev_en) begin
         prev_mem[mem_req.wr_prev_addr[AW-1:0]] <= mem_req.wr_prev_data[AW-1:0];
      end
      if (mem_req.rd_en) begin
         rd_prev_ff <= prev_mem[mem_req.rd_prev_addr[AW-1:0]];
      end
   end

   assign mem_rsp.next_node = fla_pkg::NW'(rd_next_ff);
   assign mem_rsp.prev_node = fla_pkg::NW'(rd_prev_ff);

endmodule

`default_nettype wire

[hdl/fla_lock_core.sv]
// ----------------------------------------------------------------------------
// fla_lock_core
// Lock holder, lease counter and queue head/tail/count registers; reads the
// link memories when a request is taken and writes them back on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_lock_core #(
   parameter int MAX_NODES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [fla_pkg::CMD_W-1:0]           req_command,
   input  wire logic [fla_pkg::NW-1:0]              req_requester_id,
   input  wire logic [fla_pkg::LEASE_W-1:0]         lease_ticks,
   output      fla_pkg::mem_req_type                mem_req,
   input  wire fla_pkg::mem_rsp_type                mem_rsp,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_granted,
   output      logic [fla_pkg::NW-1:0]              rsp_granted_id,
   output      logic                                rsp_holder_valid,
   output      logic [fla_pkg::NW-1:0]              rsp_holder_id,
   output      logic [fla_pkg::COUNT_OUT_W-1:0]     rsp_waiting_count,
   output      logic [fla_pkg::OUTCOME_W-1:0]       rsp_outcome
);

   localparam int NODE_COUNT = (MAX_NODES < fla_pkg::NODE_LIMIT) ? MAX_NODES
                                                                  : fla_pkg::NODE_LIMIT;
   localparam int IW = $clog2(NODE_COUNT);
   localparam int CW = $clog2(NODE_COUNT + 1);

   fla_pkg::fsm_state_type state_ff, state_in;

   logic [fla_pkg::CMD_W-1:0]   cmd_ff;
   logic [fla_pkg::NW-1:0]      id_ff;
   logic                        holder_valid_ff, holder_valid_in;
   logic [fla_pkg::NW-1:0]      holder_ff, holder_in;
   logic [fla_pkg::LEASE_W-1:0] lease_left_ff, lease_left_in;
   logic [IW-1:0]               head_ff, head_in;
   logic [IW-1:0]               tail_ff, tail_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [NODE_COUNT-1:0]       waiting_ff, waiting_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            granted_ff, granted_in;
   logic [fla_pkg::NW-1:0]          granted_id_ff, granted_id_in;
   logic [fla_pkg::OUTCOME_W-1:0]   outcome_ff, outcome_in;

   logic          accept;
   logic          commit;
   logic          use_head;
   logic          id_ok;
   logic [IW-1:0] idx;
   logic          is_waiting;
   logic          release_req;
   logic [IW-1:0] rd_next;
   logic [IW-1:0] rd_prev;

   assign accept = req_valid && (state_ff == fla_pkg::ST_IDLE);
   assign commit = (state_ff == fla_pkg::ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != fla_pkg::ST_IDLE);

   // ticks and releases read the head's next link, all else the requester's links
   assign use_head = (req_command == fla_pkg::CMD_TICK) ||
                     ((req_command == fla_pkg::CMD_UNLOCK) && holder_valid_ff &&
                      (holder_ff == req_requester_id));

   assign id_ok = (32'(id_ff) < 32'(MAX_NODES));
   assign idx = id_ff[IW-1:0];
   assign is_waiting = id_ok && waiting_ff[idx];
   assign rd_next = mem_rsp.next_node[IW-1:0];
   assign rd_prev = mem_rsp.prev_node[IW-1:0];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fla_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = fla_pkg::ST_EXEC;
            end
         end
         fla_pkg::ST_EXEC: begin
            if (commit) begin
               state_in = fla_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fla_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      holder_valid_in = holder_valid_ff;
      holder_in       = holder_ff;
      lease_left_in   = lease_left_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      waiting_in      = waiting_ff;
      granted_in      = 1'b0;
      granted_id_in   = '0;
      outcome_in      = fla_pkg::OC_IGNORED;
      release_req     = 1'b0;

      mem_req.rd_en        = accept;
      mem_req.rd_next_addr = use_head ? fla_pkg::NW'(head_ff) : req_requester_id;
      mem_req.rd_prev_addr = req_requester_id;
      mem_req.wr_next_en   = 1'b0;
      mem_req.wr_next_addr = fla_pkg::NW'(tail_ff);
      mem_req.wr_next_data = id_ff;
      mem_req.wr_prev_en   = 1'b0;
      mem_req.wr_prev_addr = id_ff;
      mem_req.wr_prev_data = fla_pkg::NW'(tail_ff);

      case (cmd_ff)
         fla_pkg::CMD_TICK: begin
            outcome_in = fla_pkg::OC_TICK;
            if (holder_valid_ff) begin
               if (lease_left_ff <= fla_pkg::LEASE_W'(1)) begin
                  outcome_in  = fla_pkg::OC_EXPIRED;
                  release_req = 1'b1;
               end else begin
                  lease_left_in = lease_left_ff - fla_pkg::LEASE_W'(1);
               end
            end
         end
         fla_pkg::CMD_LOCK: begin
            if (id_ok) begin
               if (!holder_valid_ff) begin
                  holder_valid_in = 1'b1;
                  holder_in       = id_ff;
                  lease_left_in   = lease_ticks;
                  granted_in      = 1'b1;
                  granted_id_in   = id_ff;
                  outcome_in      = fla_pkg::OC_GRANTED;
               end else if (is_waiting) begin
                  outcome_in = fla_pkg::OC_ALREADY;
               end else if (count_ff < CW'(NODE_COUNT)) begin
                  outcome_in      = fla_pkg::OC_QUEUED;
                  waiting_in[idx] = 1'b1;
                  count_in        = count_ff + CW'(1);
                  tail_in         = idx;
                  if (count_ff == '0) begin
                     head_in = idx;
                  end else begin
                     // link old tail forward to us and us back to it
                     mem_req.wr_next_en = commit;
                     mem_req.wr_prev_en = commit;
                  end
               end
            end
         end
         fla_pkg::CMD_UNLOCK: begin
            if (id_ok) begin
               if (holder_valid_ff && (holder_ff == id_ff)) begin
                  outcome_in  = fla_pkg::OC_RELEASED;
                  release_req = 1'b1;
               end else if (is_waiting) begin
                  outcome_in      = fla_pkg::OC_WITHDRAWN;
                  waiting_in[idx] = 1'b0;
                  count_in        = count_ff - CW'(1);
                  // unlink from the queue, moving head or tail or patching the neighbours
                  if (idx == head_ff) begin
                     head_in = rd_next;
                  end else begin
                     mem_req.wr_next_en   = commit;
                     mem_req.wr_next_addr = fla_pkg::NW'(rd_prev);
                     mem_req.wr_next_data = fla_pkg::NW'(rd_next);
                  end
                  if (idx == tail_ff) begin
                     tail_in = rd_prev;
                  end else begin
                     mem_req.wr_prev_en   = commit;
                     mem_req.wr_prev_addr = fla_pkg::NW'(rd_next);
                     mem_req.wr_prev_data = fla_pkg::NW'(rd_prev);
                  end
               end
            end
         end
         default: begin
            outcome_in = fla_pkg::OC_IGNORED;
         end
      endcase

      // free the lock and hand it to the queue head, if anyone waits
      if (release_req) begin
         holder_valid_in = 1'b0;
         holder_in       = '0;
         lease_left_in   = '0;
         if (count_ff != '0) begin
            holder_valid_in     = 1'b1;
            holder_in           = fla_pkg::NW'(head_ff);
            lease_left_in       = lease_ticks;
            granted_in          = 1'b1;
            granted_id_in       = fla_pkg::NW'(head_ff);
            waiting_in[head_ff] = 1'b0;
            count_in            = count_ff - CW'(1);
            head_in             = rd_next;
         end
      end

      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= fla_pkg::ST_IDLE;
         holder_valid_ff <= 1'b0;
         holder_ff       <= '0;
         lease_left_ff   <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
         count_ff        <= '0;
         waiting_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            holder_valid_ff <= holder_valid_in;
            holder_ff       <= holder_in;
            lease_left_ff   <= lease_left_in;
            head_ff         <= head_in;
            tail_ff         <= tail_in;
            count_ff        <= count_in;
            waiting_ff      <= waiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         id_ff  <= req_requester_id;
      end
      if (commit) begin
         granted_ff    <= granted_in;
         granted_id_ff <= granted_id_in;
         outcome_ff    <= outcome_in;
      end
   end

   // holder and queue registers change only on commit, so they match the result
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = granted_ff;
   assign rsp_granted_id    = granted_id_ff;
   assign rsp_holder_valid  = holder_valid_ff;
   assign rsp_holder_id     = holder_ff;
   assign rsp_waiting_count = fla_pkg::COUNT_OUT_W'(count_ff);
   assign rsp_outcome       = outcome_ff;

endmodule

`default_nettype wire

[hdl/fifo_lock_arbiter_with_lease_top.sv]
// ----------------------------------------------------------------------------
// fifo_lock_arbiter_with_lease_top
// Single shared lock with a first-come wait queue and a lease per grant.
//
// Request channel (req_): command (lock, unlock, tick) and requester id,
// taken when req_valid is high and req_stall low. Every request gives one
// result on the rsp_ channel: new grant, holder after the request, number of
// waiters and an outcome code.
// The link memories are read as a request is taken and written back on
// commit, when the result is loaded into the output register. A new
// request is taken only once the last one has been committed.
// The result register holds while rsp_stall is high. One more request can be
// taken meanwhile, but it is not finished until the result is taken, and
// req_stall stays high until then.
// The user must write the lease length through csr_wr_en/csr_wr_data only
// while idle, not enforced by the block. Reset frees the lock, empties the
// queue and sets the lease to 1000 ticks; the queue links need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_lock_arbiter_with_lease_top #(
   parameter int MAX_NODES = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [fla_pkg::CMD_W-1:0]           req_command,
   input  wire logic [fla_pkg::NW-1:0]              req_requester_id,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_granted,
   output      logic [fla_pkg::NW-1:0]              rsp_granted_id,
   output      logic                                rsp_holder_valid,
   output      logic [fla_pkg::NW-1:0]              rsp_holder_id,
   output      logic [fla_pkg::COUNT_OUT_W-1:0]     rsp_waiting_count,
   output      logic [fla_pkg::OUTCOME_W-1:0]       rsp_outcome,
   input  wire logic                                csr_wr_en,
   input  wire logic [fla_pkg::LEASE_W-1:0]         csr_wr_data
);

   localparam int NODE_COUNT = (MAX_NODES < fla_pkg::NODE_LIMIT) ? MAX_NODES
                                                                  : fla_pkg::NODE_LIMIT;

   logic [fla_pkg::LEASE_W-1:0] lease_ticks_ff;
   fla_pkg::mem_req_type        mem_req;
   fla_pkg::mem_rsp_type        mem_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         lease_ticks_ff <= fla_pkg::LEASE_RESET;
      end else if (csr_wr_en) begin
         lease_ticks_ff <= csr_wr_data;
      end
   end

   fla_link_mem #(
      .DEPTH (NODE_COUNT)
   ) u_link_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   fla_lock_core #(
      .MAX_NODES (MAX_NODES)
   ) u_lock_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_requester_id  (req_requester_id),
      .lease_ticks       (lease_ticks_ff),
      .mem_req           (mem_req),
      .mem_rsp           (mem_rsp),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted       (rsp_granted),
      .rsp_granted_id    (rsp_granted_id),
      .rsp_holder_valid  (rsp_holder_valid),
      .rsp_holder_id     (rsp_holder_id),
      .rsp_waiting_count (rsp_waiting_count),
      .rsp_outcome       (rsp_outcome)
   );

endmodule

`default_nettype wire

[hdl/fla_checker.sv]
// ----------------------------------------------------------------------------
// fla_checker
// Port-level checks of the lock arbiter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fla_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic                                rsp_granted,
   input wire logic [fla_pkg::NW-1:0]              rsp_granted_id,
   input wire logic                                rsp_holder_valid,
   input wire logic [fla_pkg::NW-1:0]              rsp_holder_id,
   input wire logic [fla_pkg::COUNT_OUT_W-1:0]     rsp_waiting_count,
   input wire logic [fla_pkg::OUTCOME_W-1:0]       rsp_outcome
);

   // a new grant always leaves that node holding the lock
   a_grant_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |-> (rsp_holder_valid && (rsp_holder_id == rsp_granted_id)))
      else $error("grant not reflected in holder");

   // grants come only from a lock on a free lock, a release or an expiry
   a_grant_outcome: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_granted) |->
         ((rsp_outcome == fla_pkg::OC_GRANTED) || (rsp_outcome == fla_pkg::OC_RELEASED) ||
          (rsp_outcome == fla_pkg::OC_EXPIRED)))
      else $error("grant with unexpected outcome");

   // nobody waits on a free lock, and its holder id reads zero
   a_free_no_waiters: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_holder_valid) |->
         ((rsp_waiting_count == '0) && (rsp_holder_id == '0)))
      else $error("waiters or holder id on a free lock");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_outcome) &&
                                    $stable(rsp_waiting_count)))
      else $error("stalled result changed");

endmodule

bind fifo_lock_arbiter_with_lease_top fla_checker u_fla_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_granted       (rsp_granted),
   .rsp_granted_id    (rsp_granted_id),
   .rsp_holder_valid  (rsp_holder_valid),
   .rsp_holder_id     (rsp_holder_id),
   .rsp_waiting_count (rsp_waiting_count),
   .rsp_outcome       (rsp_outcome)
);

`default_nettype wire
